@@ sv/bat_pkg.sv @@
// Shared constants, codes and types of the bounded array table engine.
`default_nettype none
package bat_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int REQ_W      = 3;
    localparam int POS_W      = 8;
    localparam int CAP_W      = 9;
    localparam int CNT_OUT_W  = 9;
    localparam int STATUS_W   = 2;

    // Cells per group of the match tree
    localparam int GROUP_SIZE  = 16;
    localparam int GROUP_IDX_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EDIT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_APPEND,
        CELL_INSERT,
        CELL_EDIT,
        CELL_DELETE,
        CELL_READ,
        CELL_FIND
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MATCH,
        FSM_GROUP,
        FSM_DONE
    } fsm_t;

endpackage
`default_nettype wire

@@ sv/bat_req_if.sv @@
// Request channel: valid, ready and the request word.
`default_nettype none
interface bat_req_if #(
    parameter int WORD_WIDTH = bat_pkg::WORD_WIDTH_DEF
);
    logic                       valid;
    logic                       ready;
    logic [bat_pkg::REQ_W-1:0]  req_type;
    logic [bat_pkg::POS_W-1:0]  position;
    logic signed [WORD_WIDTH-1:0] data_word;

    modport source (output valid, output req_type, output position, output data_word,
                    input ready);
    modport sink   (input valid, input req_type, input position, input data_word,
                    output ready);
endinterface
`default_nettype wire

@@ sv/bat_rsp_if.sv @@
// Result channel: valid, ready and the result word.
`default_nettype none
interface bat_rsp_if #(
    parameter int WORD_WIDTH = bat_pkg::WORD_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [bat_pkg::STATUS_W-1:0]    status;
    logic signed [WORD_WIDTH-1:0]    read_word;
    logic                            hit;
    logic [bat_pkg::POS_W-1:0]       hit_index;
    logic [bat_pkg::CNT_OUT_W-1:0]   count;
    logic                            empty;
    logic                            is_full;

    modport source (output valid, output status, output read_word, output hit,
                    output hit_index, output count, output empty, output is_full,
                    input ready);
    modport sink   (input valid, input status, input read_word, input hit,
                    input hit_index, input count, input empty, input is_full,
                    output ready);
endinterface
`default_nettype wire

@@ sv/bat_cfg_if.sv @@
// Configuration write channel carrying the capacity word.
`default_nettype none
interface bat_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bat_pkg::CAP_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/bat_cell.sv @@
// One storage cell of the array: holds an entry, shifts with its neighbours, compares.
`default_nettype none
module bat_cell #(
    parameter int WORD_WIDTH = bat_pkg::WORD_WIDTH_DEF,
    parameter int CMP_W      = 9,
    parameter int INDEX      = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bat_pkg::cell_op_t     op,
    input  wire logic [CMP_W-1:0]      pos,
    input  wire logic [CMP_W-1:0]      count,
    input  wire logic [WORD_WIDTH-1:0] data,
    input  wire logic [WORD_WIDTH-1:0] low_word,
    input  wire logic [WORD_WIDTH-1:0] high_word,
    output logic      [WORD_WIDTH-1:0] word,
    output logic                       match
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  match_reg;
    logic                  match_next;

    always_comb
    begin
        word_next  = word_reg;
        match_next = 1'b0;
        case (op)
            bat_pkg::CELL_APPEND:
            begin
                if (IDX == count)
                begin
                    word_next = data;
                end
            end
            bat_pkg::CELL_INSERT:
            begin
                // take the lower neighbour across the shifted tail
                if (IDX == pos)
                begin
                    word_next = data;
                end
                else if (IDX > pos && IDX <= count)
                begin
                    word_next = low_word;
                end
            end
            bat_pkg::CELL_EDIT:
            begin
                if (IDX == pos)
                begin
                    word_next = data;
                end
            end
            bat_pkg::CELL_DELETE:
            begin
                if (IDX >= pos)
                begin
                    word_next = high_word;
                end
            end
            bat_pkg::CELL_READ:
            begin
                match_next = (IDX == pos);
            end
            bat_pkg::CELL_FIND:
            begin
                match_next = (IDX < count) && (word_reg == data);
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule
`default_nettype wire

@@ sv/bat_group.sv @@
// Group stage of the match tree: first matching cell of a group and its entry.
`default_nettype none
module bat_group #(
    parameter int WORD_WIDTH = bat_pkg::WORD_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [bat_pkg::GROUP_SIZE-1:0]       match,
    input  wire logic [WORD_WIDTH-1:0]                words [bat_pkg::GROUP_SIZE],
    output logic                                      any,
    output logic      [bat_pkg::GROUP_IDX_W-1:0]      sub_index,
    output logic      [WORD_WIDTH-1:0]                word
);

    localparam int GS  = bat_pkg::GROUP_SIZE;
    localparam int GIW = bat_pkg::GROUP_IDX_W;

    logic                  any_reg;
    logic [GIW-1:0]        sub_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic                  any_next;
    logic [GIW-1:0]        sub_next;
    logic [WORD_WIDTH-1:0] word_next;

    always_comb
    begin
        any_next  = 1'b0;
        sub_next  = '0;
        word_next = '0;
        // scan downwards so the lowest match wins
        for (int k = GS - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                any_next  = 1'b1;
                sub_next  = GIW'(k);
                word_next = words[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg  <= sub_next;
        word_reg <= word_next;
    end

    assign any       = any_reg;
    assign sub_index = sub_reg;
    assign word      = word_reg;

endmodule
`default_nettype wire

@@ sv/bounded_array_table_engine_top.sv @@
// Bounded array table engine: row of entry cells, match tree, control and result register.
// Append, insert, edit, delete and rejected requests: one pass through the cells, then
// the result word is loaded once the result channel is free; the next request follows.
// Read and find: result set by the cell compare, the group encoder and the group select
// of the match tree; no new request is taken until the result word is loaded.
// Reset: count 0, capacity 256, result channel empty; entries undefined until written,
// no clearing pass.
`default_nettype none
module bounded_array_table_engine_top #(
    parameter int DEPTH      = bat_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = bat_pkg::WORD_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bat_cfg_if.sink    cfg,
    bat_req_if.sink    req,
    bat_rsp_if.source  rsp
);

    localparam int GS     = bat_pkg::GROUP_SIZE;
    localparam int GIW    = bat_pkg::GROUP_IDX_W;
    localparam int NGROUP = (DEPTH + GS - 1) / GS;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > bat_pkg::CAP_W) ? CNT_W : bat_pkg::CAP_W;
    localparam int PW     = bat_pkg::POS_W;
    localparam int SW     = bat_pkg::STATUS_W;
    localparam int COW    = bat_pkg::CNT_OUT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    bat_pkg::fsm_t state_reg;
    bat_pkg::fsm_t state_next;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [bat_pkg::CAP_W-1:0] capacity_reg;

    logic [SW-1:0]         res_status_reg, res_status_next;
    logic [WORD_WIDTH-1:0] res_word_reg,   res_word_next;
    logic                  res_hit_reg,    res_hit_next;
    logic [PW-1:0]         res_index_reg,  res_index_next;
    logic                  find_reg,       find_next;

    logic                  out_valid_reg,  out_valid_next;
    logic [SW-1:0]         out_status_reg;
    logic [WORD_WIDTH-1:0] out_word_reg;
    logic                  out_hit_reg;
    logic [PW-1:0]         out_index_reg;
    logic [COW-1:0]        out_count_reg;
    logic                  out_empty_reg;
    logic                  out_full_reg;
    logic                  out_load;

    bat_pkg::cell_op_t     cell_op;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic                  full;
    logic                  req_fire;

    logic [WORD_WIDTH-1:0] cell_word  [NGROUP*GS];
    logic [NGROUP*GS-1:0]  cell_match;

    logic                  grp_any    [NGROUP];
    logic [GIW-1:0]        grp_sub    [NGROUP];
    logic [WORD_WIDTH-1:0] grp_word   [NGROUP];

    logic                  sel_hit;
    logic [CMP_W-1:0]      sel_index;
    logic [WORD_WIDTH-1:0] sel_word;

    assign pos_ext   = CMP_W'(req.position);
    assign count_ext = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(capacity_reg);
    assign eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign full      = (count_ext >= eff_cap);

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == bat_pkg::FSM_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_load  = (state_reg == bat_pkg::FSM_DONE) && (!out_valid_reg || rsp.ready);

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] low_w;
            logic [WORD_WIDTH-1:0] high_w;
            if (gi == 0)
            begin : g_first
                assign low_w = '0;
            end
            else
            begin : g_inner_low
                assign low_w = cell_word[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign high_w = '0;
            end
            else
            begin : g_inner_high
                assign high_w = cell_word[gi+1];
            end
            bat_cell #(
                .WORD_WIDTH (WORD_WIDTH),
                .CMP_W      (CMP_W),
                .INDEX      (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (cell_op),
                .pos       (pos_ext),
                .count     (count_ext),
                .data      (req.data_word),
                .low_word  (low_w),
                .high_word (high_w),
                .word      (cell_word[gi]),
                .match     (cell_match[gi])
            );
        end
        for (gi = DEPTH; gi < NGROUP*GS; gi++)
        begin : g_pad
            assign cell_word[gi]  = '0;
            assign cell_match[gi] = 1'b0;
        end
        for (gi = 0; gi < NGROUP; gi++)
        begin : g_grp
            bat_group #(
                .WORD_WIDTH (WORD_WIDTH)
            ) u_group (
                .clk       (clk),
                .rst_n     (rst_n),
                .match     (cell_match[gi*GS +: GS]),
                .words     (cell_word[gi*GS : gi*GS + GS - 1]),
                .any       (grp_any[gi]),
                .sub_index (grp_sub[gi]),
                .word      (grp_word[gi])
            );
        end
    endgenerate

    // Pick the lowest group holding a match
    always_comb
    begin
        sel_hit   = 1'b0;
        sel_index = '0;
        sel_word  = '0;
        for (int g = NGROUP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                sel_hit   = 1'b1;
                sel_index = CMP_W'(g * GS) + CMP_W'(grp_sub[g]);
                sel_word  = grp_word[g];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cell_op         = bat_pkg::CELL_IDLE;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        res_hit_next    = res_hit_reg;
        res_index_next  = res_index_reg;
        find_next       = find_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bat_pkg::FSM_IDLE:
            begin
                if (req_fire)
                begin
                    res_status_next = bat_pkg::STAT_DONE;
                    res_word_next   = '0;
                    res_hit_next    = 1'b0;
                    res_index_next  = '0;
                    find_next       = 1'b0;
                    state_next      = bat_pkg::FSM_DONE;
                    case (req.req_type)
                        bat_pkg::REQ_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = bat_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cell_op    = bat_pkg::CELL_APPEND;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bat_pkg::REQ_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = bat_pkg::STAT_FULL;
                            end
                            else if (pos_ext >= count_ext)
                            begin
                                res_status_next = bat_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cell_op    = bat_pkg::CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bat_pkg::REQ_EDIT:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                res_status_next = bat_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cell_op = bat_pkg::CELL_EDIT;
                            end
                        end
                        bat_pkg::REQ_DELETE:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                res_status_next = bat_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cell_op    = bat_pkg::CELL_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        bat_pkg::REQ_READ:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                res_status_next = bat_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cell_op    = bat_pkg::CELL_READ;
                                state_next = bat_pkg::FSM_MATCH;
                            end
                        end
                        bat_pkg::REQ_FIND:
                        begin
                            cell_op    = bat_pkg::CELL_FIND;
                            find_next  = 1'b1;
                            state_next = bat_pkg::FSM_MATCH;
                        end
                        default:
                        begin
                            // unknown code: change nothing, report done
                            cell_op = bat_pkg::CELL_IDLE;
                        end
                    endcase
                end
            end
            bat_pkg::FSM_MATCH:
            begin
                state_next = bat_pkg::FSM_GROUP;
            end
            bat_pkg::FSM_GROUP:
            begin
                res_status_next = bat_pkg::STAT_DONE;
                if (find_reg)
                begin
                    res_word_next  = '0;
                    res_hit_next   = sel_hit;
                    res_index_next = sel_hit ? sel_index[PW-1:0] : '0;
                end
                else
                begin
                    res_word_next  = sel_word;
                    res_hit_next   = 1'b0;
                    res_index_next = '0;
                end
                state_next = bat_pkg::FSM_DONE;
            end
            bat_pkg::FSM_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = bat_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = bat_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bat_pkg::FSM_IDLE;
            count_reg     <= '0;
            capacity_reg  <= bat_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
            find_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            find_reg      <= find_next;
            if (cfg.valid && cfg.ready)
            begin
                capacity_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        res_hit_reg    <= res_hit_next;
        res_index_reg  <= res_index_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_word_reg   <= res_word_reg;
            out_hit_reg    <= res_hit_reg;
            out_index_reg  <= res_index_reg;
            out_count_reg  <= COW'(count_reg);
            out_empty_reg  <= (count_reg == '0);
            out_full_reg   <= full;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.read_word = out_word_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.hit_index = out_index_reg;
    assign rsp.count     = out_count_reg;
    assign rsp.empty     = out_empty_reg;
    assign rsp.is_full   = out_full_reg;

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the bounded array table engine: directed and random requests.
`default_nettype none
module tb;

    localparam int DEPTH  = bat_pkg::DEPTH_DEF;
    localparam int WORD_W = bat_pkg::WORD_WIDTH_DEF;

    // Request codes that the engine ignores
    localparam logic [bat_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [bat_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef enum int {GROW, MIXED, SHRINK} op_mix_t;

    typedef struct packed {
        logic [bat_pkg::REQ_W-1:0] kind;
        logic [bat_pkg::POS_W-1:0] pos;
        logic signed [WORD_W-1:0]  data;
    } request_t;

    typedef struct packed {
        logic [bat_pkg::STATUS_W-1:0]  status;
        logic signed [WORD_W-1:0]      read_word;
        logic                          hit;
        logic [bat_pkg::POS_W-1:0]     hit_index;
        logic [bat_pkg::CNT_OUT_W-1:0] count;
        logic                          empty;
        logic                          is_full;
    } outcome_t;

    // Shadow copy of the array; predicts one outcome per accepted request
    class array_scoreboard;
        logic signed [WORD_W-1:0] cells [DEPTH];
        int unsigned              fill;
        int unsigned              cap;
        outcome_t                 pending [$];
        int unsigned              faults;

        function new();
            fill   = 0;
            cap    = bat_pkg::CAP_RESET;
            faults = 0;
        endfunction

        function void set_capacity(logic [bat_pkg::CAP_W-1:0] v);
            cap = v;
        endfunction

        function void note_request(request_t r);
            outcome_t    e;
            int unsigned lim;
            bit          full;
            int          i;
            lim  = (cap > DEPTH) ? DEPTH : cap;
            full = fill >= lim;
            e    = '0;
            e.status = bat_pkg::STAT_DONE;
            case (r.kind)
                bat_pkg::REQ_APPEND:
                    if (full)
                        e.status = bat_pkg::STAT_FULL;
                    else
                    begin
                        cells[fill] = r.data;
                        fill++;
                    end
                bat_pkg::REQ_INSERT:
                    if (full)
                        e.status = bat_pkg::STAT_FULL;
                    else if (r.pos >= fill)
                        e.status = bat_pkg::STAT_RANGE;
                    else
                    begin
                        for (i = fill; i > r.pos; i--)
                            cells[i] = cells[i-1];
                        cells[r.pos] = r.data;
                        fill++;
                    end
                bat_pkg::REQ_EDIT:
                    if (r.pos >= fill)
                        e.status = bat_pkg::STAT_RANGE;
                    else
                        cells[r.pos] = r.data;
                bat_pkg::REQ_DELETE:
                    if (r.pos >= fill)
                        e.status = bat_pkg::STAT_RANGE;
                    else
                    begin
                        for (i = r.pos; i + 1 < fill; i++)
                            cells[i] = cells[i+1];
                        fill--;
                    end
                bat_pkg::REQ_READ:
                    if (r.pos >= fill)
                        e.status = bat_pkg::STAT_RANGE;
                    else
                        e.read_word = cells[r.pos];
                bat_pkg::REQ_FIND:
                    for (i = 0; i < fill; i++)
                        if (cells[i] == r.data)
                        begin
                            e.hit       = 1'b1;
                            e.hit_index = 8'(i);
                            break;
                        end
                default:
                    ;
            endcase
            e.count   = 9'(fill);
            e.empty   = (fill == 0);
            e.is_full = (fill >= lim);
            pending.push_back(e);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %h, actual %h", name, want, seen);
                faults++;
            end
        endfunction

        function void check_result(outcome_t got);
            outcome_t e;
            if (pending.size() == 0)
            begin
                $error("result word with no request outstanding");
                faults++;
                return;
            end
            e = pending.pop_front();
            compare_field("status",    32'(e.status),    32'(got.status));
            compare_field("read_word", e.read_word,      got.read_word);
            compare_field("hit",       32'(e.hit),       32'(got.hit));
            compare_field("hit_index", 32'(e.hit_index), 32'(got.hit_index));
            compare_field("count",     32'(e.count),     32'(got.count));
            compare_field("empty",     32'(e.empty),     32'(got.empty));
            compare_field("is_full",   32'(e.is_full),   32'(got.is_full));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bat_cfg_if cfg_ch ();
    bat_req_if req_ch ();
    bat_rsp_if rsp_ch ();

    bounded_array_table_engine_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    array_scoreboard sb;
    int              burst_left;
    int unsigned     stall_tick = 0;
    int unsigned     stall_mode = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #200000;
        $display("tb: failure");
        $finish;
    end

    // Watch both channels and feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request('{req_ch.req_type, req_ch.position, req_ch.data_word});
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result('{rsp_ch.status, rsp_ch.read_word, rsp_ch.hit,
                                  rsp_ch.hit_index, rsp_ch.count, rsp_ch.empty,
                                  rsp_ch.is_full});
        end
    end

    // Receiver stalls: one of four patterns, picked anew at random while the bench runs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            if (stall_tick % 64 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2: rsp_ch.ready <= stall_tick[0];
                default: rsp_ch.ready <= (stall_tick % 7 == 0);
            endcase
        end
    end

    task automatic push_request(input logic [bat_pkg::REQ_W-1:0] kind,
                                input logic [bat_pkg::POS_W-1:0] pos,
                                input logic [WORD_W-1:0] data);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.position  <= pos;
        req_ch.data_word <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Hold the sender off until every outstanding word has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [bat_pkg::CAP_W-1:0] v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_capacity(v);
        @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'(signed'($urandom_range(0, 3)));
            4, 5:
                if (sb.fill > 0)
                    return sb.cells[$urandom_range(0, sb.fill - 1)];
                else
                    return $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bat_pkg::REQ_W-1:0] pick_kind(op_mix_t mix);
        int unsigned r;
        int unsigned t [6];
        r = $urandom_range(0, 99);
        case (mix)
            GROW:    t = '{50, 80, 84, 88, 93, 98};
            MIXED:   t = '{20, 35, 50, 68, 82, 97};
            default: t = '{5, 10, 20, 70, 82, 97};
        endcase
        if (r < t[0]) return bat_pkg::REQ_APPEND;
        if (r < t[1]) return bat_pkg::REQ_INSERT;
        if (r < t[2]) return bat_pkg::REQ_EDIT;
        if (r < t[3]) return bat_pkg::REQ_DELETE;
        if (r < t[4]) return bat_pkg::REQ_READ;
        if (r < t[5]) return bat_pkg::REQ_FIND;
        return $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    endfunction

    task automatic run_phase(input logic [bat_pkg::CAP_W-1:0] cap, input int n,
                             input op_mix_t mix);
        logic [bat_pkg::POS_W-1:0] pos;
        int                        gap;
        write_capacity(cap);
        burst_left = 0;
        repeat (n)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    gap        = 0;
                    burst_left = 40;
                end
                else
                begin
                    gap        = $urandom_range(1, 5);
                    burst_left = $urandom_range(1, 12);
                end
                if (gap > 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            // Mostly address filled entries; the rest spans the whole field
            if (sb.fill > 0 && $urandom_range(0, 9) < 8)
                pos = bat_pkg::POS_W'($urandom_range(0, sb.fill - 1));
            else
                pos = bat_pkg::POS_W'($urandom_range(0, 255));
            push_request(pick_kind(mix), pos, pick_word());
        end
    endtask

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= bat_pkg::REQ_APPEND;
        req_ch.position  <= '0;
        req_ch.data_word <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(bat_pkg::CAP_RESET);
        // Empty array: every indexed request is out of range
        push_request(bat_pkg::REQ_READ,   8'd0,   32'h1234_5678);
        push_request(bat_pkg::REQ_DELETE, 8'd0,   32'h0);
        push_request(bat_pkg::REQ_EDIT,   8'd0,   32'hFFFF_FFFF);
        push_request(bat_pkg::REQ_INSERT, 8'd0,   32'h7FFF_FFFF);
        push_request(bat_pkg::REQ_FIND,   8'd0,   32'h0);
        push_request(bat_pkg::REQ_APPEND, 8'd255, 32'h7FFF_FFFF);
        push_request(bat_pkg::REQ_APPEND, 8'd0,   32'h8000_0000);
        push_request(bat_pkg::REQ_APPEND, 8'd0,   32'hFFFF_FFFF);
        push_request(bat_pkg::REQ_INSERT, 8'd0,   32'h0);
        push_request(bat_pkg::REQ_INSERT, 8'd2,   32'hFFFF_FFFF);
        push_request(bat_pkg::REQ_READ,   8'd255, 32'h0);
        push_request(bat_pkg::REQ_FIND,   8'd0,   32'hFFFF_FFFF);
        push_request(bat_pkg::REQ_EDIT,   8'd1,   32'h5555_5555);
        push_request(bat_pkg::REQ_READ,   8'd1,   32'h0);
        push_request(bat_pkg::REQ_EDIT,   8'd255, 32'hAAAA_AAAA);
        push_request(bat_pkg::REQ_INSERT, 8'd5,   32'h1);
        push_request(bat_pkg::REQ_DELETE, 8'd4,   32'h0);
        push_request(bat_pkg::REQ_DELETE, 8'd0,   32'h0);
        push_request(bat_pkg::REQ_READ,   8'd0,   32'h0);
        push_request(REQ_SPARE_LO,        8'd255, 32'hFFFF_FFFF);
        push_request(REQ_SPARE_HI,        8'd0,   32'h8000_0000);
        push_request(bat_pkg::REQ_FIND,   8'd0,   32'hAAAA_AAAA);

        // Capacity below the count: full at once, entries kept, full beats range
        write_capacity(9'd0);
        push_request(bat_pkg::REQ_APPEND, 8'd0,   32'h1);
        push_request(bat_pkg::REQ_INSERT, 8'd255, 32'h2);
        push_request(bat_pkg::REQ_READ,   8'd0,   32'h0);

        run_phase(9'd4,   80,  MIXED);
        run_phase(9'd1,   30,  MIXED);
        run_phase(9'd0,   20,  MIXED);
        run_phase(9'd511, 400, GROW);
        run_phase(9'd256, 30,  GROW);
        run_phase(9'd10,  120, SHRINK);
        run_phase(9'($urandom_range(1, 300)), 50, MIXED);

        drain();
        repeat (8) @(posedge clk);
        if (sb.faults == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
